@@ rtl/core/sfd_pkg.sv @@
// Package for the SBUS frame decoder: payload structs, control structs,
// register indexes and frame constants. No dependencies.
`default_nettype none
package sfd_pkg;

   localparam int CHANNEL_COUNT = 16;
   localparam int CHANNEL_BITS  = 11;
   localparam int FRAME_BYTES   = 25;

   localparam int CH_IDX_W   = $clog2(CHANNEL_COUNT);
   localparam int BYTE_CNT_W = 5;
   localparam int ACC_W      = 18;
   localparam int HELD_W     = 5;
   localparam int DONE_W     = 5;

   localparam logic [BYTE_CNT_W-1:0] POS_FIRST     = BYTE_CNT_W'(0);
   localparam logic [BYTE_CNT_W-1:0] POS_LAST_DATA = BYTE_CNT_W'(22);
   localparam logic [BYTE_CNT_W-1:0] POS_FLAGS     = BYTE_CNT_W'(23);
   localparam logic [BYTE_CNT_W-1:0] POS_END       = BYTE_CNT_W'(FRAME_BYTES - 1);
   localparam logic [BYTE_CNT_W-1:0] POS_SAT       = BYTE_CNT_W'(FRAME_BYTES + 1);

   localparam int LOST_BIT     = 2;
   localparam int FAILSAFE_BIT = 3;

   localparam logic [7:0] START_RESET = 8'h0F;
   localparam logic [7:0] END_RESET   = 8'h00;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE   = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } sfd_req_type;

   typedef struct packed {
      logic                    frame_ok;
      logic [CH_IDX_W-1:0]     channel_index;
      logic [CHANNEL_BITS-1:0] channel_value;
      logic                    link_lost;
      logic                    failsafe;
      logic                    last_result;
   } sfd_rsp_type;

   typedef struct packed {
      logic take;
      logic emit;
   } sfd_cmd_type;

   typedef struct packed {
      logic end_good;
      logic last_chan;
      logic out_free;
   } sfd_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/sfd_ctrl.sv @@
// Controller for the SBUS frame decoder: collect and readout states.
// Depends on sfd_pkg.
`default_nettype none
module sfd_ctrl
   import sfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire sfd_stat_type stat,
   output sfd_cmd_type       cmd
);

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_READOUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      req_stall = (state_ff == ST_READOUT) || !stat.out_free;
      cmd.take  = req_valid && !req_stall;
      cmd.emit  = (state_ff == ST_READOUT) && stat.out_free;
      state_in  = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (cmd.take && stat.end_good) state_in = ST_READOUT;
         end
         ST_READOUT: begin
            if (cmd.emit && stat.last_chan) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sfd_datapath.sv @@
// Datapath for the SBUS frame decoder: byte count, bit unpacker, channel
// store, flags, config registers and result register. Depends on sfd_pkg.
`default_nettype none
module sfd_datapath
   import sfd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire sfd_req_type            req_data,
   input  wire sfd_cmd_type            cmd,
   output sfd_stat_type                stat,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output sfd_rsp_type                 rsp_data
);

   localparam sfd_rsp_type BAD_RSP = '{frame_ok: 1'b0, channel_index: '0,
                                       channel_value: '0, link_lost: 1'b0,
                                       failsafe: 1'b0, last_result: 1'b1};

   logic [7:0]              start_ff, end_ff;
   logic [BYTE_CNT_W-1:0]   count_ff, count_in;
   logic                    first_ok_ff, first_ok_in;
   logic [ACC_W-1:0]        acc_ff, acc_in, acc_or;
   logic [HELD_W-1:0]       held_ff, held_in, held_sum;
   logic [DONE_W-1:0]       done_ff, done_in;
   logic                    lost_ff, lost_in, fs_ff, fs_in;
   logic [CH_IDX_W-1:0]     idx_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sfd_rsp_type             rsp_data_ff;
   logic                    store_wr, load_bad;
   logic [CHANNEL_BITS-1:0] chan_mem [CHANNEL_COUNT];

   assign stat.end_good  = req_data.frame_end && (count_ff == POS_END) && first_ok_ff &&
                           (req_data.data_byte == end_ff);
   assign stat.last_chan = (idx_ff == CH_IDX_W'(CHANNEL_COUNT - 1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_bad       = cmd.take && req_data.frame_end && !stat.end_good;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

   always_comb begin
      acc_or      = acc_ff | (ACC_W'(req_data.data_byte) << held_ff);
      held_sum    = held_ff + HELD_W'(8);
      count_in    = count_ff;
      first_ok_in = first_ok_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      done_in     = done_ff;
      lost_in     = lost_ff;
      fs_in       = fs_ff;
      store_wr    = 1'b0;
      if (count_ff == POS_FIRST) begin
         first_ok_in = (req_data.data_byte == start_ff);
      end else if (count_ff <= POS_LAST_DATA) begin
         acc_in  = acc_or;
         held_in = held_sum;
         if ((held_sum >= HELD_W'(CHANNEL_BITS)) &&
             (done_ff < DONE_W'(CHANNEL_COUNT))) begin
            store_wr = 1'b1;
            acc_in   = acc_or >> CHANNEL_BITS;
            held_in  = held_sum - HELD_W'(CHANNEL_BITS);
            done_in  = done_ff + DONE_W'(1);
         end
      end else if (count_ff == POS_FLAGS) begin
         lost_in = req_data.data_byte[LOST_BIT];
         fs_in   = req_data.data_byte[FAILSAFE_BIT];
      end
      if (count_ff < POS_SAT) count_in = count_ff + BYTE_CNT_W'(1);
      if (req_data.frame_end) begin
         count_in    = '0;
         first_ok_in = 1'b0;
         acc_in      = '0;
         held_in     = '0;
         done_in     = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_bad || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RESET;
         end_ff       <= END_RESET;
         count_ff     <= '0;
         first_ok_ff  <= 1'b0;
         acc_ff       <= '0;
         held_ff      <= '0;
         done_ff      <= '0;
         lost_ff      <= 1'b0;
         fs_ff        <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_BYTE: start_ff <= csr_wdata;
               CSR_END_BYTE:   end_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.take) begin
            count_ff    <= count_in;
            first_ok_ff <= first_ok_in;
            acc_ff      <= acc_in;
            held_ff     <= held_in;
            done_ff     <= done_in;
            lost_ff     <= lost_in;
            fs_ff       <= fs_in;
            idx_ff      <= '0;
         end else if (cmd.emit) begin
            idx_ff <= idx_ff + CH_IDX_W'(1);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && store_wr) begin
         chan_mem[done_ff[CH_IDX_W-1:0]] <= acc_or[CHANNEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_bad) begin
         rsp_data_ff <= BAD_RSP;
      end else if (cmd.emit) begin
         rsp_data_ff.frame_ok      <= 1'b1;
         rsp_data_ff.channel_index <= idx_ff;
         rsp_data_ff.channel_value <= chan_mem[idx_ff];
         rsp_data_ff.link_lost     <= lost_ff;
         rsp_data_ff.failsafe      <= fs_ff;
         rsp_data_ff.last_result   <= stat.last_chan;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sbus_frame_decoder.sv @@
// Top level of the SBUS frame decoder: controller plus datapath.
// Depends on sfd_pkg, sfd_ctrl, sfd_datapath.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/stall    sfd_req_type (data_byte, frame_end)
//   rsp_        out        rsp_valid/stall    sfd_rsp_type (one channel result)
//   csr_        in         csr_wr_en          csr_index, csr_wdata
//
// A byte is taken while no readout runs and the result register is free. A good frame
// end starts a readout of 16 transactions from the 16-entry channel store port, one per
// cycle while the result register is free; input stays stalled until the last is loaded.
// A bad frame end loads one result in the same cycle as the byte.
// Synchronous reset clears the count, unpacker and flags and restores the start and
// end registers; the channel store is not reset.
`default_nettype none
module sbus_frame_decoder
   import sfd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sfd_req_type            req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sfd_rsp_type                 rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata
);

   sfd_cmd_type  cmd;
   sfd_stat_type stat;

   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_bad_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_ok |->
         rsp_data.last_result && (rsp_data.channel_value == '0) &&
         (rsp_data.channel_index == '0) && !rsp_data.link_lost && !rsp_data.failsafe)
      else $error("bad frame result carries data");

   a_last_on_final_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_ok |->
         (rsp_data.last_result == (rsp_data.channel_index == CH_IDX_W'(CHANNEL_COUNT - 1))))
      else $error("last_result mismatch on channel index");

   a_stall_during_readout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_ok && !rsp_data.last_result |-> req_stall)
      else $error("input taken during readout");

   a_readout_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.frame_ok && !rsp_data.last_result |=>
         rsp_valid && rsp_data.frame_ok &&
         (rsp_data.channel_index == $past(rsp_data.channel_index) + CH_IDX_W'(1)))
      else $error("readout skipped or stalled a channel");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sbus_frame_decoder: byte-level frame stimulus with
// random gaps and stalls, a transaction-level frame decoder predictor and an in-order
// result scoreboard. Depends on sfd_pkg and the sbus_frame_decoder RTL.
module testbench
   import sfd_pkg::*;
();

   localparam int IDLE_PCT      = 27;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEM_TARGET   = 310;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_kind_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sfd_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sfd_rsp_type            rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_START_BYTE;
   logic [7:0]             csr_wdata = 8'h00;

   logic steady = 1'b0;
   int   cycle_count    = 0;
   int   mismatch_count = 0;
   int   results_checked = 0;
   int   frames_good    = 0;
   int   frames_bad     = 0;
   int   bytes_sent     = 0;
   int   config_writes  = 0;

   sfd_rsp_type results_due[$];

   logic [7:0]              cfg_start = START_RESET;
   logic [7:0]              cfg_end   = END_RESET;
   logic [BYTE_CNT_W-1:0]   pred_count = '0;
   logic                    pred_start_ok = 1'b0;
   int unsigned             pred_acc = 0;
   int                      pred_held = 0;
   int                      pred_done = 0;
   logic [7:0]              pred_flags = 8'h00;
   logic [CHANNEL_BITS-1:0] chan_store [CHANNEL_COUNT];

   sbus_frame_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, results_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void decode_sbus_byte(input logic [7:0] b, input logic mark);
      logic [BYTE_CNT_W-1:0] pos;
      sfd_rsp_type           r;
      int                    k;
      pos = pred_count;
      if (pos == POS_FIRST) begin
         pred_start_ok = (b == cfg_start);
      end else if (pos <= POS_LAST_DATA) begin
         pred_acc = pred_acc | (32'(b) << pred_held);
         pred_held += 8;
         while (pred_held >= CHANNEL_BITS && pred_done < CHANNEL_COUNT) begin
            chan_store[pred_done] = pred_acc[CHANNEL_BITS-1:0];
            pred_acc = pred_acc >> CHANNEL_BITS;
            pred_held -= CHANNEL_BITS;
            pred_done++;
         end
         pred_acc &= 32'h3FFFF;
      end else if (pos == POS_FLAGS) begin
         pred_flags = b;
      end
      if (pred_count <= FRAME_BYTES) pred_count++;
      if (!mark) return;
      r = '0;
      if (pos == POS_END && pred_start_ok && b == cfg_end) begin
         for (k = 0; k < CHANNEL_COUNT; k++) begin
            r.frame_ok      = 1'b1;
            r.channel_index = CH_IDX_W'(k);
            r.channel_value = chan_store[k];
            r.link_lost     = pred_flags[LOST_BIT];
            r.failsafe      = pred_flags[FAILSAFE_BIT];
            r.last_result   = (k == CHANNEL_COUNT - 1);
            results_due = {results_due, r};
         end
         frames_good++;
      end else begin
         r.last_result = 1'b1;
         results_due = {results_due, r};
         frames_bad++;
      end
      pred_count    = '0;
      pred_start_ok = 1'b0;
      pred_acc      = 0;
      pred_held     = 0;
      pred_done     = 0;
      pred_flags    = 8'h00;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      sfd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = results_due.pop_front();
            check_field("frame_ok", want.frame_ok, rsp_data.frame_ok);
            check_field("channel_index", want.channel_index, rsp_data.channel_index);
            check_field("channel_value", want.channel_value, rsp_data.channel_value);
            check_field("link_lost", want.link_lost, rsp_data.link_lost);
            check_field("failsafe", want.failsafe, rsp_data.failsafe);
            check_field("last_result", want.last_result, rsp_data.last_result);
            results_checked++;
         end
      end
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic send_byte(input logic [7:0] b, input logic mark);
      sfd_req_type item;
      item.data_byte = b;
      item.frame_end = mark;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      decode_sbus_byte(b, mark);
      bytes_sent++;
   endtask

   task automatic send_frame(input int len, input logic [7:0] first, input logic [7:0] flags,
                             input logic [7:0] last, input fill_kind_type fill);
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         if (i == 0) b = first;
         else if (i == len - 1) b = last;
         else if (i == int'(POS_FLAGS)) b = flags;
         else begin
            case (fill)
               FILL_ZERO: b = 8'h00;
               FILL_ONES: b = 8'hFF;
               default:   b = 8'($urandom);
            endcase
         end
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] start_val, input logic [7:0] end_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_wdata <= start_val;
      @(posedge clock);
      cfg_start = start_val;
      csr_index <= CSR_END_BYTE;
      csr_wdata <= end_val;
      @(posedge clock);
      cfg_end = end_val;
      csr_wr_en <= 1'b0;
      config_writes++;
   endtask

   task automatic test_reset_config();
      send_frame(FRAME_BYTES, START_RESET, 8'h0C, END_RESET, FILL_ONES);
      wait_idle();
   endtask

   task automatic test_framing_errors();
      send_frame(1, cfg_start, 8'h00, cfg_end, FILL_RANDOM);
      send_frame(FRAME_BYTES - 1, cfg_start, 8'h08, cfg_end, FILL_RANDOM);
      send_frame(FRAME_BYTES + 1, cfg_start, 8'h08, cfg_end, FILL_RANDOM);
      send_frame(FRAME_BYTES, cfg_start ^ 8'h80, 8'h0C, cfg_end, FILL_RANDOM);
      send_frame(FRAME_BYTES, cfg_start, 8'h0C, cfg_end ^ 8'h01, FILL_RANDOM);
      wait_idle();
   endtask

   task automatic test_config_extremes();
      set_config(8'h00, 8'hFF);
      send_frame(FRAME_BYTES, 8'h00, 8'hF3, 8'hFF, FILL_RANDOM);
      wait_idle();
      set_config(8'hFF, 8'h00);
      send_frame(FRAME_BYTES, 8'hFF, 8'h0C, 8'h00, FILL_ZERO);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int frame_no;
      int pick;
      int n;
      int i;
      frame_no = 0;
      while (bytes_sent < ITEM_TARGET) begin
         if (frame_no % 5 == 4) begin
            wait_idle();
            case ($urandom_range(3))
               0:       set_config(8'h00, 8'h00);
               1:       set_config(8'hFF, 8'hFF);
               default: set_config(8'($urandom), 8'($urandom));
            endcase
         end
         steady = (frame_no >= 1 && frame_no < 4);
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame(FRAME_BYTES, cfg_start, 8'($urandom), cfg_end, FILL_RANDOM);
         end else if (pick < 72) begin
            send_frame($urandom_range(1, FRAME_BYTES - 1), cfg_start, 8'($urandom), cfg_end,
                       FILL_RANDOM);
         end else if (pick < 79) begin
            send_frame($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6), cfg_start,
                       8'($urandom), cfg_end, FILL_RANDOM);
         end else if (pick < 86) begin
            send_frame(FRAME_BYTES, cfg_start ^ 8'($urandom_range(1, 255)), 8'($urandom),
                       cfg_end, FILL_RANDOM);
         end else if (pick < 93) begin
            send_frame(FRAME_BYTES, cfg_start, 8'($urandom),
                       cfg_end ^ 8'($urandom_range(1, 255)), FILL_RANDOM);
         end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               send_byte(8'($urandom), (i == n - 1) || ($urandom_range(7) == 0));
         end
         frame_no++;
      end
      steady = 1'b0;
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_framing_errors();
      test_config_extremes();
      test_random_traffic();
      wait_idle();
      if (results_due.size() != 0) begin
         $display("%0t: %0d expected transactions never arrived", $time, results_due.size());
         mismatch_count++;
      end
      $display("Covered %0d bytes in %0d good and %0d rejected frames, %0d results checked,",
               bytes_sent, frames_good, frames_bad, results_checked);
      $display("%0d start/end register settings, %0d mismatches", config_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/sfd_pkg.sv
rtl/core/sfd_ctrl.sv
rtl/core/sfd_datapath.sv
rtl/core/sbus_frame_decoder.sv
tb/sv/testbench.sv
